// ----- rtl/bct_pkg.sv -----
// package for the binary contour tracer: item types, codes, control structs, step tables
`timescale 1ns / 1ps
`default_nettype none
package bct_pkg;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    localparam int CFG_AW = 2;
    localparam int CFG_DW = 13;

    localparam logic [CFG_AW-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_MIN_POINTS   = 2'd2;

    localparam logic [6:0]  RST_IMAGE_WIDTH  = 7'd64;
    localparam logic [6:0]  RST_IMAGE_HEIGHT = 7'd64;
    localparam logic [12:0] RST_MIN_POINTS   = 13'd10;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_FETCH = 1'b1;

    typedef struct packed {
        logic       action;
        logic [5:0] pixel_x;
        logic [5:0] pixel_y;
        logic       pixel_on;
    } t_in_item;

    typedef struct packed {
        logic [5:0] point_x;
        logic [5:0] point_y;
        logic       end_of_contour;
        logic       scan_done;
    } t_out_item;

    typedef struct packed {
        logic clr_step;
        logic restart;
        logic load_pix;
        logic scan_row;
        logic scan_next;
        logic trace_start;
        logic push;
        logic rd_nb;
        logic nb_next;
        logic move;
        logic emit_clr;
        logic emit_step;
        logic out_load;
        logic out_done;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic scan_end;
        logic scan_edge;
        logic hit;
        logic nb_oob;
        logic k_last;
        logic close_hit;
        logic keep;
        logic emit_last;
        logic out_free;
    } t_dp_sts;

    // two's complement steps, direction 0 is +x, counting clockwise in image rows
    function automatic logic [1:0] step_dx(input logic [2:0] d);
        logic [1:0] r;
        case (d)
            3'd0, 3'd1, 3'd7: r = 2'b01;
            3'd3, 3'd4, 3'd5: r = 2'b11;
            default:          r = 2'b00;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] step_dy(input logic [2:0] d);
        logic [1:0] r;
        case (d)
            3'd1, 3'd2, 3'd3: r = 2'b01;
            3'd5, 3'd6, 3'd7: r = 2'b11;
            default:          r = 2'b00;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/binary_contour_tracer_core.sv -----
// top level of the binary contour tracer
`timescale 1ns / 1ps
`default_nettype none
// binary contour tracer. a load item (action 0) writes one pixel of a binary
// image and restarts the scan; a fetch item (action 1) returns the next point
// of the next kept contour, or scan_done once no contour is left. interior
// pixels are scanned in raster order; from each unvisited on-pixel the block
// follows unvisited on-neighbors greedily over eight directions and keeps the
// contour if it has at least min_points points. a load gives no result, a
// fetch gives exactly one. a fetch that emits a stored point reads it from the
// contour memory, then loads the result register; a fetch that must find a
// contour first reads each scanned pixel, steps rows at the image edge, and
// for each traced pixel marks it visited, then tests up to 8 neighbors in turn,
// reading those inside the image serially through the one registered read port
// of the pixel and visited memories. the visited map is wiped by a clearing
// pass over all MAX_HEIGHT * 2**clog2(MAX_WIDTH) entries after reset and on
// the first restart (load or config write) after any trace; items are stalled
// during the pass, config writes are still taken. the user must make config
// writes only while the block is idle; the block itself does not enforce it.
module binary_contour_tracer_core #(
    parameter int MAX_WIDTH  = bct_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bct_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input items
    input  wire logic                          i_in_valid,
    input  wire bct_pkg::t_in_item             i_in_data,
    output logic                               o_in_stall,
    // result items
    output logic                               o_out_valid,
    output bct_pkg::t_out_item                 o_out_data,
    input  wire logic                          i_out_stall,
    // config writes
    input  wire logic                          i_cfg_we,
    input  wire logic [bct_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  wire logic [bct_pkg::CFG_DW-1:0]    i_cfg_data
);
    import bct_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencing of clear, scan, trace and emit
    bct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_in_data.action),
        .o_in_stall (o_in_stall),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // memories, coordinates, counters and the result register
    bct_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );
endmodule
`default_nettype wire

// ----- rtl/bct_ram.sv -----
// generic simple dual port ram, one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none
module bct_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ----- rtl/bct_ctrl.sv -----
// controller state machine of the contour tracer
`timescale 1ns / 1ps
`default_nettype none
module bct_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_action,
    output logic                               o_in_stall,
    input  wire logic                          i_cfg_we,
    input  wire logic [bct_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  wire bct_pkg::t_dp_sts              i_sts,
    output bct_pkg::t_dp_cmd                   o_cmd
);
    import bct_pkg::*;

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_SCAN    = 4'd2;
    localparam logic [3:0] S_SCAN_EV = 4'd3;
    localparam logic [3:0] S_PUSH    = 4'd4;
    localparam logic [3:0] S_NB      = 4'd5;
    localparam logic [3:0] S_NB_EV   = 4'd6;
    localparam logic [3:0] S_EMIT_RD = 4'd7;
    localparam logic [3:0] S_OUT     = 4'd8;

    localparam logic [1:0] PH_SCAN = 2'd0;
    localparam logic [1:0] PH_EMIT = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    logic [3:0] r_state, n_state;
    logic [1:0] r_phase, n_phase;
    logic       r_dirty, n_dirty;
    logic       accept;
    logic       cfg_restart;
    logic       do_restart;
    logic       do_close;
    t_dp_cmd    cmd;

    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_we;
    assign accept      = i_in_valid && !o_in_stall;
    assign cfg_restart = i_cfg_we && (i_cfg_addr == CFG_IMAGE_WIDTH ||
                         i_cfg_addr == CFG_IMAGE_HEIGHT || i_cfg_addr == CFG_MIN_POINTS);

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_dirty    = r_dirty;
        cmd        = '0;
        do_restart = cfg_restart;
        do_close   = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                    n_dirty = 1'b0;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_action == ACT_LOAD) begin
                        cmd.load_pix = 1'b1;
                        do_restart   = 1'b1;
                    end else if (r_phase == PH_SCAN) begin
                        n_state = S_SCAN;
                    end else if (r_phase == PH_EMIT) begin
                        n_state = S_EMIT_RD;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_SCAN: begin
                if (i_sts.scan_end) begin
                    n_phase = PH_DONE;
                    n_state = S_OUT;
                end else if (i_sts.scan_edge) begin
                    cmd.scan_row = 1'b1;
                end else begin
                    n_state = S_SCAN_EV;
                end
            end
            S_SCAN_EV: begin
                if (i_sts.hit) begin
                    cmd.trace_start = 1'b1;
                    n_state         = S_PUSH;
                end else begin
                    cmd.scan_next = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_PUSH: begin
                cmd.push = 1'b1;
                n_dirty  = 1'b1;
                n_state  = S_NB;
            end
            S_NB: begin
                if (i_sts.nb_oob) begin
                    if (i_sts.k_last) begin
                        do_close = 1'b1;
                    end else begin
                        cmd.nb_next = 1'b1;
                    end
                end else begin
                    cmd.rd_nb = 1'b1;
                    n_state   = S_NB_EV;
                end
            end
            S_NB_EV: begin
                cmd.rd_nb = 1'b1;
                if (i_sts.hit) begin
                    cmd.move = 1'b1;
                    if (i_sts.close_hit) begin
                        do_close = 1'b1;
                    end else begin
                        n_state = S_PUSH;
                    end
                end else if (i_sts.k_last) begin
                    do_close = 1'b1;
                end else begin
                    cmd.nb_next = 1'b1;
                    n_state     = S_NB;
                end
            end
            S_EMIT_RD: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                cmd.out_done = (r_phase != PH_EMIT);
                if (i_sts.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                    if (r_phase == PH_EMIT) begin
                        cmd.emit_step = 1'b1;
                        if (i_sts.emit_last) begin
                            n_phase = PH_SCAN;
                        end
                    end
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase

        // contour finished: step the scan on, keep it or go on scanning
        if (do_close) begin
            cmd.scan_next = 1'b1;
            if (i_sts.keep) begin
                cmd.emit_clr = 1'b1;
                n_phase      = PH_EMIT;
                n_state      = S_EMIT_RD;
            end else begin
                n_state = S_SCAN;
            end
        end

        if (do_restart) begin
            cmd.restart = 1'b1;
            n_phase     = PH_SCAN;
            if (r_dirty || r_state == S_CLEAR) begin
                n_state = S_CLEAR;
            end
        end
    end

    assign o_cmd = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_phase <= PH_SCAN;
            r_dirty <= 1'b1;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_dirty <= n_dirty;
        end
    end

`ifndef SYNTH
    a_load_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_action == ACT_LOAD) |=> (r_phase == PH_SCAN))
        else $error("load did not restart the scan");
    a_push_marks_dirty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |=> r_dirty)
        else $error("visited write not tracked");
    a_out_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> i_sts.out_free)
        else $error("result written over a pending result");
    a_move_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.move |-> !i_sts.nb_oob)
        else $error("trace moved outside the image");
`endif
endmodule
`default_nettype wire

// ----- rtl/bct_dp.sv -----
// datapath of the contour tracer: scan and trace registers, memories, result register
`timescale 1ns / 1ps
`default_nettype none
module bct_dp #(
    parameter int MAX_WIDTH  = bct_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bct_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire bct_pkg::t_in_item             i_in_data,
    input  wire logic                          i_cfg_we,
    input  wire logic [bct_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  wire logic [bct_pkg::CFG_DW-1:0]    i_cfg_data,
    input  wire bct_pkg::t_dp_cmd              i_cmd,
    output bct_pkg::t_dp_sts                   o_sts,
    output logic                               o_out_valid,
    output bct_pkg::t_out_item                 o_out_data,
    input  wire logic                          i_out_stall
);
    import bct_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int WW    = XW + 1;
    localparam int HW    = YW + 1;
    localparam int AW    = XW + YW;
    localparam int VDEPTH = MAX_HEIGHT * (2 ** XW);
    localparam int NUM   = MAX_WIDTH * MAX_HEIGHT;
    localparam int CAW   = $clog2(NUM);
    localparam int LW    = $clog2(NUM + 1);

    // config registers
    logic [6:0]  r_width;
    logic [6:0]  r_height;
    logic [12:0] r_min;

    // scan, trace and emit state
    logic [XW-1:0] r_sx_scan;
    logic [YW-1:0] r_sy_scan;
    logic [XW-1:0] r_cx, r_sx;
    logic [YW-1:0] r_cy, r_sy;
    logic [2:0]    r_dir;
    logic [2:0]    r_k;
    logic [LW-1:0] r_len;
    logic [LW-1:0] r_emit;
    logic [AW-1:0] r_clr;
    logic          r_out_valid;
    t_out_item     r_out_data;

    logic [WW+6:0] w_ext;
    logic [HW+6:0] h_ext;
    logic [WW-1:0] used_w;
    logic [HW-1:0] used_h;
    logic [2:0]    dir_k;
    logic [1:0]    dx, dy;
    logic [WW-1:0] nx;
    logic [HW-1:0] ny;
    logic [AW-1:0] nb_addr, scan_addr, cur_addr, rd_addr;
    logic          pix_rd, vis_rd;
    logic [XW+5:0] px_ext;
    logic [YW+5:0] py_ext;
    logic          pix_in_range;
    logic [AW-1:0] ld_addr;
    logic          vis_we;
    logic [AW-1:0] vis_waddr;
    logic [XW+YW-1:0] ctr_rdata;
    logic [XW+5:0] ox_ext;
    logic [YW+5:0] oy_ext;
    logic [LW:0]   emit_nx;
    logic [LW+12:0] len_cmp, min_cmp;
    t_out_item     res;

    // size in use, saturated to 3..max
    always_comb begin
        w_ext = {{WW{1'b0}}, r_width};
        h_ext = {{HW{1'b0}}, r_height};
        if (w_ext < (WW+7)'(3)) begin
            used_w = WW'(3);
        end else if (w_ext > (WW+7)'(MAX_WIDTH)) begin
            used_w = WW'(MAX_WIDTH);
        end else begin
            used_w = w_ext[WW-1:0];
        end
        if (h_ext < (HW+7)'(3)) begin
            used_h = HW'(3);
        end else if (h_ext > (HW+7)'(MAX_HEIGHT)) begin
            used_h = HW'(MAX_HEIGHT);
        end else begin
            used_h = h_ext[HW-1:0];
        end
    end

    // neighbor under test
    assign dir_k   = r_dir + r_k;
    assign dx      = step_dx(dir_k);
    assign dy      = step_dy(dir_k);
    assign nx      = {1'b0, r_cx} + {{(WW-2){dx[1]}}, dx};
    assign ny      = {1'b0, r_cy} + {{(HW-2){dy[1]}}, dy};
    assign nb_addr   = {ny[YW-1:0], nx[XW-1:0]};
    assign scan_addr = {r_sy_scan, r_sx_scan};
    assign cur_addr  = {r_cy, r_cx};
    assign rd_addr   = i_cmd.rd_nb ? nb_addr : scan_addr;

    // pixel load address
    assign px_ext       = {{XW{1'b0}}, i_in_data.pixel_x};
    assign py_ext       = {{YW{1'b0}}, i_in_data.pixel_y};
    assign pix_in_range = (px_ext < (XW+6)'(MAX_WIDTH)) && (py_ext < (YW+6)'(MAX_HEIGHT));
    assign ld_addr      = {py_ext[YW-1:0], px_ext[XW-1:0]};

    assign vis_we    = i_cmd.clr_step || i_cmd.push;
    assign vis_waddr = i_cmd.clr_step ? r_clr : cur_addr;

    bct_ram #(.WIDTH(1), .DEPTH(VDEPTH)) u_pix_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_pix && pix_in_range),
        .i_waddr (ld_addr),
        .i_wdata (i_in_data.pixel_on),
        .i_raddr (rd_addr),
        .o_rdata (pix_rd)
    );

    bct_ram #(.WIDTH(1), .DEPTH(VDEPTH)) u_vis_ram (
        .i_clk   (i_clk),
        .i_we    (vis_we),
        .i_waddr (vis_waddr),
        .i_wdata (i_cmd.push),
        .i_raddr (rd_addr),
        .o_rdata (vis_rd)
    );

    bct_ram #(.WIDTH(XW + YW), .DEPTH(NUM)) u_ctr_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_len[CAW-1:0]),
        .i_wdata ({r_cy, r_cx}),
        .i_raddr (r_emit[CAW-1:0]),
        .o_rdata (ctr_rdata)
    );

    // status
    assign emit_nx = {1'b0, r_emit} + (LW+1)'(1);
    assign len_cmp = {13'd0, r_len};
    assign min_cmp = {{LW{1'b0}}, r_min};

    always_comb begin
        o_sts           = '0;
        o_sts.clr_last  = (r_clr == AW'(VDEPTH - 1));
        o_sts.scan_end  = ({1'b0, r_sy_scan} + HW'(1)) >= used_h;
        o_sts.scan_edge = (r_sx_scan == '0) || (({1'b0, r_sx_scan} + WW'(1)) >= used_w);
        o_sts.hit       = pix_rd && !vis_rd;
        o_sts.nb_oob    = (nx >= used_w) || (ny >= used_h);
        o_sts.k_last    = (r_k == 3'd7);
        // return to start stays in, though the start pixel is visited already
        o_sts.close_hit = ((r_len > LW'(2)) && (nx == {1'b0, r_sx}) && (ny == {1'b0, r_sy}))
                          || (r_len >= LW'(NUM));
        o_sts.keep      = len_cmp >= min_cmp;
        o_sts.emit_last = emit_nx >= {1'b0, r_len};
        o_sts.out_free  = !r_out_valid || !i_out_stall;
    end

    // result item
    assign ox_ext = {6'd0, ctr_rdata[XW-1:0]};
    assign oy_ext = {6'd0, ctr_rdata[XW+YW-1:XW]};

    always_comb begin
        res = '0;
        if (i_cmd.out_done) begin
            res.scan_done = 1'b1;
        end else begin
            res.point_x        = ox_ext[5:0];
            res.point_y        = oy_ext[5:0];
            res.end_of_contour = o_sts.emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= RST_IMAGE_WIDTH;
            r_height    <= RST_IMAGE_HEIGHT;
            r_min       <= RST_MIN_POINTS;
            r_sx_scan   <= XW'(1);
            r_sy_scan   <= YW'(1);
            r_dir       <= '0;
            r_k         <= '0;
            r_len       <= '0;
            r_emit      <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data[6:0];
                    CFG_IMAGE_HEIGHT: r_height <= i_cfg_data[6:0];
                    CFG_MIN_POINTS:   r_min    <= i_cfg_data;
                    default:          ;
                endcase
            end
            if (i_cmd.clr_step) begin
                r_clr <= o_sts.clr_last ? '0 : r_clr + AW'(1);
            end
            if (i_cmd.restart) begin
                r_sx_scan <= XW'(1);
                r_sy_scan <= YW'(1);
                r_len     <= '0;
                r_emit    <= '0;
                r_dir     <= '0;
            end else begin
                if (i_cmd.scan_row) begin
                    r_sx_scan <= XW'(1);
                    r_sy_scan <= r_sy_scan + YW'(1);
                end else if (i_cmd.scan_next) begin
                    r_sx_scan <= r_sx_scan + XW'(1);
                end
                if (i_cmd.trace_start) begin
                    r_dir <= '0;
                    r_len <= '0;
                end else if (i_cmd.push) begin
                    r_len <= r_len + LW'(1);
                    r_k   <= '0;
                end else if (i_cmd.move) begin
                    r_dir <= dir_k + 3'd6;
                end else if (i_cmd.nb_next) begin
                    r_k <= r_k + 3'd1;
                end
                if (i_cmd.emit_clr) begin
                    r_emit <= '0;
                end else if (i_cmd.emit_step) begin
                    r_emit <= r_emit + LW'(1);
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // trace coordinates and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.trace_start) begin
            r_cx <= r_sx_scan;
            r_cy <= r_sy_scan;
            r_sx <= r_sx_scan;
            r_sy <= r_sy_scan;
        end else if (i_cmd.move) begin
            r_cx <= nx[XW-1:0];
            r_cy <= ny[YW-1:0];
        end
        if (i_cmd.out_load) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
// self-checking testbench for binary_contour_tracer_core
`timescale 1ns / 1ps
module tb_top;
    import bct_pkg::*;

    localparam int NPIX       = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
    localparam int QUIET_MAX  = 300000;

    typedef enum int {SEEKING, EMITTING, FINISHED} t_tracer_phase;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            in_valid = 1'b0;
    t_in_item        in_data = '0;
    logic            in_stall;
    logic            out_valid;
    t_out_item       out_data;
    logic            out_stall = 1'b0;
    logic            cfg_we = 1'b0;
    logic [CFG_AW-1:0] cfg_addr = '0;
    logic [CFG_DW-1:0] cfg_data = '0;

    binary_contour_tracer_core uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_data(in_data), .o_in_stall(in_stall),
        .o_out_valid(out_valid), .o_out_data(out_data), .i_out_stall(out_stall),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // pending items and expected points
    t_in_item  pending_items[$];
    t_out_item expected_points[$];
    bit        calm = 1'b0;
    int        err_cnt = 0;
    int        items_taken = 0;
    int        points_seen = 0;
    int        contours_seen = 0;
    int        quiet = 0;

    // shadow of the tracer
    bit            img_on[NPIX];
    bit            img_written[NPIX];
    bit            seen_map[NPIX];
    int            outline[NPIX];
    int            outline_len, emit_pos, scan_pos, trace_pos, search_dir;
    t_tracer_phase tr_phase;
    int            cfg_w, cfg_h, cfg_min;
    bit            done_reported;
    int            dx_tab[8] = '{1, 1, 0, -1, -1, -1, 0, 1};
    int            dy_tab[8] = '{0, 1, 1, 1, 0, -1, -1, -1};

    function automatic int clamp_dim(int v, int hi);
        return (v < 3) ? 3 : ((v > hi) ? hi : v);
    endfunction

    task automatic restart_scan();
        foreach (seen_map[i]) seen_map[i] = 1'b0;
        outline_len = 0;
        emit_pos = 0;
        scan_pos = DEF_MAX_WIDTH + 1;
        trace_pos = 0;
        search_dir = 0;
        tr_phase = SEEKING;
        done_reported = 1'b0;
    endtask

    // greedy walk over unvisited on-neighbors
    task automatic follow_outline(int sx, int sy, int w, int h);
        int cx, cy, len, dir, found, d, nx, ny, ni, idx;
        bit closed;
        cx = sx; cy = sy; len = 0; dir = 0; closed = 1'b0;
        while (!closed) begin
            idx = cy * DEF_MAX_WIDTH + cx;
            outline[len] = idx;
            len++;
            seen_map[idx] = 1'b1;
            found = -1;
            for (int k = 0; k < 8 && found < 0; k++) begin
                d = (dir + k) % 8;
                nx = cx + dx_tab[d];
                ny = cy + dy_tab[d];
                if (nx >= 0 && nx < w && ny >= 0 && ny < h) begin
                    ni = ny * DEF_MAX_WIDTH + nx;
                    if (img_on[ni] && !seen_map[ni]) found = d;
                end
            end
            if (found >= 0) begin
                cx += dx_tab[found];
                cy += dy_tab[found];
                dir = (found + 6) % 8;
            end else begin
                closed = 1'b1;
            end
            // return to start, kept although the start is already visited
            if (len > 2 && cx == sx && cy == sy) closed = 1'b1;
            if (len >= NPIX) closed = 1'b1;
        end
        outline_len = len;
        trace_pos = cy * DEF_MAX_WIDTH + cx;
        search_dir = dir;
    endtask

    task automatic seek_outline();
        int w, h, x, y;
        w = clamp_dim(cfg_w, DEF_MAX_WIDTH);
        h = clamp_dim(cfg_h, DEF_MAX_HEIGHT);
        while (tr_phase == SEEKING) begin
            x = scan_pos % DEF_MAX_WIDTH;
            y = scan_pos / DEF_MAX_WIDTH;
            if (y >= h - 1) begin
                tr_phase = FINISHED;
            end else if (x < 1 || x >= w - 1) begin
                scan_pos = (y + 1) * DEF_MAX_WIDTH + 1;
            end else if (img_on[scan_pos] && !seen_map[scan_pos]) begin
                follow_outline(x, y, w, h);
                scan_pos++;
                if (outline_len >= cfg_min) begin
                    emit_pos = 0;
                    tr_phase = EMITTING;
                end
            end else begin
                scan_pos++;
            end
        end
    endtask

    // expected result of one accepted item
    task automatic model_item(t_in_item it);
        t_out_item r;
        int p;
        if (it.action == ACT_LOAD) begin
            img_on[it.pixel_y * DEF_MAX_WIDTH + it.pixel_x] = it.pixel_on;
            restart_scan();
        end else begin
            if (tr_phase == SEEKING) seek_outline();
            r = '0;
            if (tr_phase != EMITTING) begin
                r.scan_done = 1'b1;
                done_reported = 1'b1;
            end else begin
                p = outline[emit_pos % NPIX];
                r.point_x = 6'(p % DEF_MAX_WIDTH);
                r.point_y = 6'(p / DEF_MAX_WIDTH);
                r.end_of_contour = (emit_pos + 1 >= outline_len);
                emit_pos++;
                if (r.end_of_contour) tr_phase = SEEKING;
            end
            expected_points.insert(expected_points.size(), r);
        end
    endtask

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t: %s", $time, what);
        err_cnt++;
    endtask

    // driver: presents queued items, idles at random
    always @(posedge clk) begin
        bit took;
        took = 1'b0;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                model_item(in_data);
                void'(pending_items.pop_front());
                items_taken++;
                took = 1'b1;
            end
            if (!in_valid || took) begin
                if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 28)) begin
                    in_data  <= pending_items[0];
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each accepted point against the oldest expectation
    always @(posedge clk) begin
        t_out_item e;
        if (rst_n && out_valid && !out_stall) begin
            points_seen++;
            if (expected_points.size() == 0) begin
                report_mismatch($sformatf("unexpected item %h", out_data));
            end else begin
                e = expected_points.pop_front();
                if (out_data.point_x != e.point_x)
                    report_mismatch($sformatf("point_x %0d, want %0d",
                                              out_data.point_x, e.point_x));
                if (out_data.point_y != e.point_y)
                    report_mismatch($sformatf("point_y %0d, want %0d",
                                              out_data.point_y, e.point_y));
                if (out_data.end_of_contour != e.end_of_contour)
                    report_mismatch($sformatf("end_of_contour %0b, want %0b",
                                              out_data.end_of_contour, e.end_of_contour));
                if (out_data.scan_done != e.scan_done)
                    report_mismatch($sformatf("scan_done %0b, want %0b",
                                              out_data.scan_done, e.scan_done));
                if (e.end_of_contour) contours_seen++;
            end
        end
        out_stall <= !calm && ($urandom_range(99) < 28);
    end

    // watchdog on cycles without any transfer
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_MAX) begin
            $display("watchdog expired at %0t", $time);
            $display("simulation failed");
            $finish;
        end
    end

    task automatic put_load(int x, int y, bit on);
        t_in_item it;
        it = '0;
        it.action = ACT_LOAD;
        it.pixel_x = 6'(x);
        it.pixel_y = 6'(y);
        it.pixel_on = on;
        img_written[y * DEF_MAX_WIDTH + x] = 1'b1;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic put_fetch();
        t_in_item it;
        it = '0;
        it.action = ACT_FETCH;
        it.pixel_x = 6'($urandom);
        it.pixel_y = 6'($urandom);
        it.pixel_on = 1'($urandom);
        pending_items.insert(pending_items.size(), it);
    endtask

    // wait until everything is through, then the tail of a load
    task automatic settle();
        while (pending_items.size() > 0 || in_valid || expected_points.size() > 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_AW-1:0] idx, int val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= CFG_DW'(val);
        @(posedge clk);
        cfg_we   <= 1'b0;
        if (idx == CFG_IMAGE_WIDTH) cfg_w = val & 127;
        else if (idx == CFG_IMAGE_HEIGHT) cfg_h = val & 127;
        else cfg_min = val & 8191;
        restart_scan();
    endtask

    // size change, then fill every pixel the tracer may read that was never loaded
    task automatic set_size(int wv, int hv, int density);
        int w, h;
        write_reg(CFG_IMAGE_WIDTH, wv);
        write_reg(CFG_IMAGE_HEIGHT, hv);
        w = clamp_dim(wv & 127, DEF_MAX_WIDTH);
        h = clamp_dim(hv & 127, DEF_MAX_HEIGHT);
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
                if (!img_written[y * DEF_MAX_WIDTH + x])
                    put_load(x, y, $urandom_range(99) < density);
    endtask

    // fetch in small batches until the shadow has reported scan done
    task automatic drain_contours();
        int rounds;
        rounds = 0;
        do begin
            repeat (6) put_fetch();
            settle();
            rounds++;
        end while (!done_reported && rounds < 400);
    endtask

    // random shapes inside the used image, plus stray loads anywhere
    task automatic draw_shapes(int w, int h);
        int x0, y0, x1, y1, kind;
        repeat ($urandom_range(1, 3)) begin
            kind = $urandom_range(3);
            x0 = $urandom_range(w - 1); x1 = $urandom_range(w - 1);
            y0 = $urandom_range(h - 1); y1 = $urandom_range(h - 1);
            if (x0 > x1) begin int t; t = x0; x0 = x1; x1 = t; end
            if (y0 > y1) begin int t; t = y0; y0 = y1; y1 = t; end
            case (kind)
                0: begin
                    for (int x = x0; x <= x1; x++) begin
                        put_load(x, y0, 1'b1); put_load(x, y1, 1'b1);
                    end
                    for (int y = y0; y <= y1; y++) begin
                        put_load(x0, y, 1'b1); put_load(x1, y, 1'b1);
                    end
                end
                1: for (int x = x0; x <= x1; x++) put_load(x, (y0 + x - x0) % h, 1'b1);
                2: repeat ($urandom_range(3, 10))
                    put_load($urandom_range(w - 1), $urandom_range(h - 1), $urandom_range(1));
                default: for (int y = y0; y <= y1; y++) put_load(x0, y, 1'b0);
            endcase
        end
        if ($urandom_range(3) == 0)
            put_load($urandom_range(63), $urandom_range(63), $urandom_range(1));
    endtask

    initial begin
        int w, h;
        cfg_w = RST_IMAGE_WIDTH;
        cfg_h = RST_IMAGE_HEIGHT;
        cfg_min = RST_MIN_POINTS;
        foreach (img_on[i]) begin
            img_on[i] = 1'b0;
            img_written[i] = 1'b0;
        end
        restart_scan();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: sizes below range saturate to 3x3, min_points 0 keeps all
        write_reg(CFG_MIN_POINTS, 0);
        set_size(0, 1, 0);
        put_fetch(); put_fetch();
        put_load(1, 1, 1'b1);
        put_fetch(); put_fetch(); put_fetch();
        settle();
        for (int y = 0; y < 3; y++) for (int x = 0; x < 3; x++) put_load(x, y, 1'b1);
        repeat (11) put_fetch();
        settle();
        // min_points above the pixel count drops everything
        write_reg(CFG_MIN_POINTS, 4096);
        put_fetch(); put_fetch();
        settle();
        write_reg(CFG_MIN_POINTS, 1);
        drain_contours();

        // random phases on small images
        for (int ph = 0; ph < 70 && items_taken < 1300; ph++) begin
            calm = (ph >= 20 && ph < 28);
            settle();
            w = $urandom_range(3, 14);
            h = $urandom_range(3, 14);
            case ($urandom_range(7))
                0: write_reg(CFG_MIN_POINTS, 0);
                1: write_reg(CFG_MIN_POINTS, $urandom_range(20, 8191));
                default: write_reg(CFG_MIN_POINTS, $urandom_range(1, 8));
            endcase
            set_size(w, h, $urandom_range(10, 50));
            draw_shapes(w, h);
            if ($urandom_range(4) == 0) begin
                put_fetch(); put_fetch();
                put_load($urandom_range(w - 1), $urandom_range(h - 1), 1'b1);
            end
            drain_contours();
        end

        // above-range width on a short image, above-range height on a narrow one
        settle();
        calm = 1'b0;
        write_reg(CFG_MIN_POINTS, 10);
        set_size(127, 3, 30);
        draw_shapes(64, 3);
        drain_contours();
        write_reg(CFG_MIN_POINTS, 2);
        set_size(5, 100, 30);
        draw_shapes(5, 64);
        drain_contours();
        write_reg(CFG_MIN_POINTS, 8191);
        put_fetch(); put_fetch();

        settle();
        repeat (50) @(posedge clk);
        if (expected_points.size() != 0)
            report_mismatch($sformatf("%0d points never arrived", expected_points.size()));
        $display("covered %0d items, %0d points checked, %0d contours", items_taken,
                 points_seen, contours_seen);
        $display("sizes from 3x3 up to 64 columns or 64 rows with saturation, min_points 0 to 8191");
        if (err_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
